FILE: rtl/core/eht_pkg.sv
// eht_pkg: shared types and codes of the extendible hash table
// no dependencies; imported by eht_cfg, extendible_hash_table_top, eht_checker and testbench
`default_nettype none

package eht_pkg;

    // register indexes on the configuration port
    localparam logic REG_INIT_DEPTH = 1'b0;
    localparam logic REG_BUCKET_CAP = 1'b1;

    // command codes
    localparam logic CMD_GET    = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // result status codes
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_HIT     = 3'd2;
    localparam logic [2:0] ST_MISS    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // field widths
    localparam int DEPTH_W = 4;
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 64;

    // one stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    // configuration seen by the core
    typedef struct packed {
        logic               rebuild;
        logic [DEPTH_W-1:0] depth;
        logic [CAP_W-1:0]   cap;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/eht_cfg.sv
// eht_cfg: configuration register file with effective depth and capacity
// depends on eht_pkg
`default_nettype none

module eht_cfg import eht_pkg::*; #(
    parameter int MAX_GLOBAL_DEPTH = 8,
    parameter int NUM_BUCKETS      = 256,
    parameter int BUCKET_SLOTS     = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [3:0] init_depth_reg;
    logic [2:0] cap_reg;
    logic       wr_en;
    logic [DEPTH_W-1:0] depth_eff;
    logic [CAP_W-1:0]   cap_eff;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_depth_reg <= 4'd2;
            cap_reg        <= 3'd4;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_INIT_DEPTH: init_depth_reg <= pwdata[3:0];
                REG_BUCKET_CAP: cap_reg        <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_INIT_DEPTH: prdata = {28'd0, init_depth_reg};
            REG_BUCKET_CAP: prdata = {29'd0, cap_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // saturate depth to the directory and bucket pool
    always_comb begin
        depth_eff = '0;
        for (int k = 0; k < 16; k++) begin
            if (k <= MAX_GLOBAL_DEPTH && k <= int'(init_depth_reg)
                && (longint'(1) << k) <= longint'(NUM_BUCKETS)) begin
                depth_eff = DEPTH_W'(k);
            end
        end
    end

    // clamp capacity to between one slot and one bucket
    always_comb begin
        if (cap_reg == 3'd0) begin
            cap_eff = CAP_W'(1);
        end else if (int'(cap_reg) > BUCKET_SLOTS) begin
            cap_eff = CAP_W'(BUCKET_SLOTS);
        end else begin
            cap_eff = CAP_W'(cap_reg);
        end
    end

    assign cfg.rebuild = wr_en && (paddr[2] == REG_INIT_DEPTH);
    assign cfg.depth   = depth_eff;
    assign cfg.cap     = cap_eff;

endmodule

`default_nettype wire

FILE: rtl/core/extendible_hash_table_top.sv
// extendible_hash_table_top: key-value store with extendible hashing
// depends on eht_pkg and eht_cfg
//
// usage
//   s_ channel: one beat is a get or an insert (cmd in tuser, key and value in tdata)
//   m_ channel: one beat per input beat (status in tuser, found_value in tdata)
//   APB port: initial_depth at 0x0 (rebuilds the table), bucket_capacity at 0x4
// sequencing
//   one item at a time through a small sequencer around memories with one read
//   and one write port each; a get or insert without split reads the directory,
//   then the bucket's depth and valid row, then compares each valid slot; the
//   next beat can be taken in the cycle after the result loads
//   a split round doubles the directory if needed, copying each old entry, takes
//   a fresh bucket, checks each directory entry for repointing, moves the valid
//   slots whose new bit differs, writes both valid rows, then starts the lookup over
// reset and rebuild
//   after reset and after a write to initial_depth the table is swept, one entry
//   a cycle, through max(2^MAX_GLOBAL_DEPTH, NUM_BUCKETS) entries; s_tready stays low
// stalls
//   the result register holds a beat while m_tready is low; the next input is
//   still accepted and its result waits until the register frees
`default_nettype none

module extendible_hash_table_top import eht_pkg::*; #(
    parameter int MAX_GLOBAL_DEPTH = 8,
    parameter int NUM_BUCKETS      = 256,
    parameter int BUCKET_SLOTS     = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // cmd [0]
    input  wire logic         s_tuser,
    // key [31:0], value [95:32]
    input  wire logic [95:0]  s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // status [2:0]
    output logic      [2:0]   m_tuser,
    // found_value [63:0]
    output logic      [63:0]  m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    localparam int DIR_ENTRIES = 1 << MAX_GLOBAL_DEPTH;
    localparam int BW       = (NUM_BUCKETS > 2) ? $clog2(NUM_BUCKETS) : 1;
    localparam int BCW      = $clog2(NUM_BUCKETS + 1);
    localparam int SW       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int SCW      = $clog2(BUCKET_SLOTS + 1);
    localparam int NSLOT    = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int SAW      = (NSLOT > 2) ? $clog2(NSLOT) : 1;
    localparam int SWEEP_N  = (DIR_ENTRIES > NUM_BUCKETS) ? DIR_ENTRIES : NUM_BUCKETS;
    localparam int CW       = $clog2(SWEEP_N + 1);
    localparam int MG       = MAX_GLOBAL_DEPTH;

    // sequencer states
    localparam logic [4:0] S_SWEEP  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LOOK   = 5'd2;
    localparam logic [4:0] S_DIRQ   = 5'd3;
    localparam logic [4:0] S_BKQ    = 5'd4;
    localparam logic [4:0] S_SRD    = 5'd5;
    localparam logic [4:0] S_SCMP   = 5'd6;
    localparam logic [4:0] S_DBL_RD = 5'd7;
    localparam logic [4:0] S_DBL_WR = 5'd8;
    localparam logic [4:0] S_SPL    = 5'd9;
    localparam logic [4:0] S_SPL2   = 5'd10;
    localparam logic [4:0] S_RP_RD  = 5'd11;
    localparam logic [4:0] S_RP_WR  = 5'd12;
    localparam logic [4:0] S_MV_RD  = 5'd13;
    localparam logic [4:0] S_MV_CHK = 5'd14;
    localparam logic [4:0] S_WB1    = 5'd15;
    localparam logic [4:0] S_WB2    = 5'd16;
    localparam logic [4:0] S_RESP   = 5'd17;

    cfg_t cfg;

    eht_cfg #(
        .MAX_GLOBAL_DEPTH (MAX_GLOBAL_DEPTH),
        .NUM_BUCKETS      (NUM_BUCKETS),
        .BUCKET_SLOTS     (BUCKET_SLOTS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // memories
    logic [BW-1:0]           dir_mem  [DIR_ENTRIES];
    logic [DEPTH_W-1:0]      ld_mem   [NUM_BUCKETS];
    logic [BUCKET_SLOTS-1:0] vld_mem  [NUM_BUCKETS];
    slot_t                   slot_mem [NSLOT];

    logic [BW-1:0]           dir_rd_reg;
    logic [DEPTH_W-1:0]      ld_rd_reg;
    logic [BUCKET_SLOTS-1:0] vld_rd_reg;
    slot_t                   slot_rd_reg;

    // control and working registers
    logic [4:0]              state_reg, state_next;
    logic                    cmd_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [VAL_W-1:0]        val_reg;
    logic [DEPTH_W-1:0]      gd_reg, gd_next;
    logic [BCW-1:0]          bc_reg, bc_next;
    logic [BW-1:0]           b_reg, b_next;
    logic [BW-1:0]           nb_reg, nb_next;
    logic [DEPTH_W-1:0]      ld_reg, ld_next;
    logic [BUCKET_SLOTS-1:0] vrow_reg, vrow_next;
    logic [BUCKET_SLOTS-1:0] nvrow_reg, nvrow_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [SCW-1:0]          sc_reg, sc_next;
    logic [SW-1:0]           dst_reg, dst_next;
    logic [2:0]              rst_reg, rst_next;
    logic [VAL_W-1:0]        rval_reg, rval_next;
    logic                    m_valid_reg, m_valid_next;
    logic [2:0]              m_status_reg;
    logic [VAL_W-1:0]        m_value_reg;
    logic                    m_load;

    // memory port controls
    logic [MG-1:0]           dir_raddr, dir_waddr;
    logic [BW-1:0]           dir_wdata;
    logic                    dir_we;
    logic [BW-1:0]           bk_raddr;
    logic [BW-1:0]           ld_waddr;
    logic [DEPTH_W-1:0]      ld_wdata;
    logic                    ld_we;
    logic [BW-1:0]           vld_waddr;
    logic [BUCKET_SLOTS-1:0] vld_wdata;
    logic                    vld_we;
    logic [SAW-1:0]          slot_raddr, slot_waddr;
    slot_t                   slot_wdata;
    logic                    slot_we;

    // derived values
    logic [MG-1:0]           gmask, lmask, upper_bit;
    logic [CW-1:0]           dir_len;
    logic [SCW-1:0]          used;
    logic [SW-1:0]           free_idx;
    logic                    split_full;
    logic                    s_acc;

    function automatic logic [SAW-1:0] slot_addr(input logic [BW-1:0] b,
                                                 input logic [SW-1:0] s);
        slot_addr = SAW'(b) * SAW'(BUCKET_SLOTS) + SAW'(s);
    endfunction

    // directory masks from global and new local depth
    always_comb begin
        for (int k = 0; k < MG; k++) begin
            gmask[k] = (k < int'(gd_reg));
            lmask[k] = (k <= int'(ld_reg));
        end
        upper_bit = '0;
        for (int k = 0; k < MG; k++) begin
            upper_bit[k] = (k == int'(gd_reg));
        end
        dir_len = CW'(1) << gd_reg;
    end

    // bucket fill and first free slot
    always_comb begin
        used     = '0;
        free_idx = '0;
        for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
            used = used + SCW'(vrow_reg[s]);
            if (!vrow_reg[s]) begin
                free_idx = SW'(s);
            end
        end
    end

    assign split_full = ((ld_reg >= gd_reg) && (int'(gd_reg) >= MG))
                        || (int'(bc_reg) >= NUM_BUCKETS);

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid & s_tready;

    // memory reads, registered
    always_ff @(posedge aclk) begin
        dir_rd_reg  <= dir_mem[dir_raddr];
        ld_rd_reg   <= ld_mem[bk_raddr];
        vld_rd_reg  <= vld_mem[bk_raddr];
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    // memory writes
    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (ld_we) begin
            ld_mem[ld_waddr] <= ld_wdata;
        end
        if (vld_we) begin
            vld_mem[vld_waddr] <= vld_wdata;
        end
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        gd_next      = gd_reg;
        bc_next      = bc_reg;
        b_next       = b_reg;
        nb_next      = nb_reg;
        ld_next      = ld_reg;
        vrow_next    = vrow_reg;
        nvrow_next   = nvrow_reg;
        cnt_next     = cnt_reg;
        sc_next      = sc_reg;
        dst_next     = dst_reg;
        rst_next     = rst_reg;
        rval_next    = rval_reg;
        m_load       = 1'b0;

        dir_raddr    = cnt_reg[MG-1:0];
        dir_waddr    = cnt_reg[MG-1:0];
        dir_wdata    = dir_rd_reg;
        dir_we       = 1'b0;
        bk_raddr     = b_reg;
        ld_waddr     = b_reg;
        ld_wdata     = ld_reg + DEPTH_W'(1);
        ld_we        = 1'b0;
        vld_waddr    = b_reg;
        vld_wdata    = vrow_reg;
        vld_we       = 1'b0;
        slot_raddr   = slot_addr(b_reg, sc_reg[SW-1:0]);
        slot_waddr   = slot_addr(b_reg, sc_reg[SW-1:0]);
        slot_wdata   = '{key: key_reg, value: val_reg};
        slot_we      = 1'b0;

        unique case (state_reg)
            // initialize directory, depths and valid rows
            S_SWEEP: begin
                gd_next = cfg.depth;
                bc_next = BCW'(1) << cfg.depth;
                dir_we  = (int'(cnt_reg) < DIR_ENTRIES);
                for (int k = 0; k < BW; k++) begin
                    dir_wdata[k] = (k < int'(cfg.depth)) ? cnt_reg[k] : 1'b0;
                end
                ld_waddr  = cnt_reg[BW-1:0];
                ld_wdata  = cfg.depth;
                ld_we     = (int'(cnt_reg) < NUM_BUCKETS);
                vld_waddr = cnt_reg[BW-1:0];
                vld_wdata = '0;
                vld_we    = (int'(cnt_reg) < NUM_BUCKETS);
                cnt_next  = cnt_reg + CW'(1);
                if (int'(cnt_reg) == SWEEP_N - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    state_next = S_LOOK;
                end
            end
            // directory read at the key's slot
            S_LOOK: begin
                dir_raddr  = key_reg[MG-1:0] & gmask;
                state_next = S_DIRQ;
            end
            S_DIRQ: begin
                b_next     = dir_rd_reg;
                bk_raddr   = dir_rd_reg;
                state_next = S_BKQ;
            end
            S_BKQ: begin
                ld_next    = ld_rd_reg;
                vrow_next  = vld_rd_reg;
                sc_next    = '0;
                state_next = S_SRD;
            end
            // walk the valid slots of the bucket, then answer a miss, insert, report full or start a split
            S_SRD: begin
                if (int'(sc_reg) == BUCKET_SLOTS) begin
                    if (cmd_reg == CMD_GET) begin
                        rst_next   = ST_MISS;
                        rval_next  = '0;
                        state_next = S_RESP;
                    end else if (CAP_W'(used) < cfg.cap) begin
                        slot_waddr = slot_addr(b_reg, free_idx);
                        slot_we    = 1'b1;
                        vld_wdata  = vrow_reg | (BUCKET_SLOTS'(1) << free_idx);
                        vld_we     = 1'b1;
                        rst_next   = ST_NEW;
                        rval_next  = '0;
                        state_next = S_RESP;
                    end else if (split_full) begin
                        rst_next   = ST_FULL;
                        rval_next  = '0;
                        state_next = S_RESP;
                    end else if (ld_reg >= gd_reg) begin
                        cnt_next   = '0;
                        state_next = S_DBL_RD;
                    end else begin
                        state_next = S_SPL;
                    end
                end else if (!vrow_reg[sc_reg[SW-1:0]]) begin
                    sc_next = sc_reg + SCW'(1);
                end else begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                if (slot_rd_reg.key == key_reg) begin
                    if (cmd_reg == CMD_GET) begin
                        rst_next  = ST_HIT;
                        rval_next = slot_rd_reg.value;
                    end else begin
                        slot_we   = 1'b1;
                        rst_next  = ST_UPDATED;
                        rval_next = '0;
                    end
                    state_next = S_RESP;
                end else begin
                    sc_next    = sc_reg + SCW'(1);
                    state_next = S_SRD;
                end
            end
            // double the directory
            S_DBL_RD: begin
                state_next = S_DBL_WR;
            end
            S_DBL_WR: begin
                dir_waddr = cnt_reg[MG-1:0] | upper_bit;
                dir_we    = 1'b1;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg + CW'(1) == dir_len) begin
                    gd_next    = gd_reg + DEPTH_W'(1);
                    state_next = S_SPL;
                end else begin
                    state_next = S_DBL_RD;
                end
            end
            // take a fresh bucket and raise both local depths
            S_SPL: begin
                nb_next    = bc_reg[BW-1:0];
                bc_next    = bc_reg + BCW'(1);
                ld_we      = 1'b1;
                nvrow_next = '0;
                state_next = S_SPL2;
            end
            S_SPL2: begin
                ld_waddr   = nb_reg;
                ld_we      = 1'b1;
                cnt_next   = '0;
                state_next = S_RP_RD;
            end
            // repoint directory entries of the split half
            S_RP_RD: begin
                state_next = S_RP_WR;
            end
            S_RP_WR: begin
                dir_wdata = nb_reg;
                dir_we    = (dir_rd_reg == b_reg)
                            && ((cnt_reg[MG-1:0] & lmask) != (key_reg[MG-1:0] & lmask));
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg + CW'(1) == dir_len) begin
                    sc_next    = '0;
                    dst_next   = '0;
                    state_next = S_MV_RD;
                end else begin
                    state_next = S_RP_RD;
                end
            end
            // move entries whose new bit differs to the fresh bucket
            S_MV_RD: begin
                if (int'(sc_reg) == BUCKET_SLOTS) begin
                    state_next = S_WB1;
                end else if (!vrow_reg[sc_reg[SW-1:0]]) begin
                    sc_next = sc_reg + SCW'(1);
                end else begin
                    state_next = S_MV_CHK;
                end
            end
            S_MV_CHK: begin
                if ((slot_rd_reg.key[MG-1:0] & lmask) != (key_reg[MG-1:0] & lmask)) begin
                    slot_waddr                   = slot_addr(nb_reg, dst_reg);
                    slot_wdata                   = slot_rd_reg;
                    slot_we                      = 1'b1;
                    nvrow_next[dst_reg]          = 1'b1;
                    vrow_next[sc_reg[SW-1:0]]    = 1'b0;
                    dst_next                     = dst_reg + SW'(1);
                end
                sc_next    = sc_reg + SCW'(1);
                state_next = S_MV_RD;
            end
            // write back both valid rows, then retry the insert
            S_WB1: begin
                vld_we     = 1'b1;
                state_next = S_WB2;
            end
            S_WB2: begin
                vld_waddr  = nb_reg;
                vld_wdata  = nvrow_reg;
                vld_we     = 1'b1;
                state_next = S_LOOK;
            end
            // hand the result to the output register
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_SWEEP;
                cnt_next   = '0;
            end
        endcase

        // a depth write rebuilds the table
        if (cfg.rebuild) begin
            state_next = S_SWEEP;
            cnt_next   = '0;
        end
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            gd_reg      <= '0;
            bc_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            gd_reg      <= gd_next;
            bc_reg      <= bc_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata[31:0];
            val_reg <= s_tdata[95:32];
        end
        b_reg     <= b_next;
        nb_reg    <= nb_next;
        ld_reg    <= ld_next;
        vrow_reg  <= vrow_next;
        nvrow_reg <= nvrow_next;
        sc_reg    <= sc_next;
        dst_reg   <= dst_next;
        rst_reg   <= rst_next;
        rval_reg  <= rval_next;
        if (m_load) begin
            m_status_reg <= rst_reg;
            m_value_reg  <= rval_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_value_reg;

    // checks
    a_bucket_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_SWEEP) |-> (int'(bc_reg) <= NUM_BUCKETS))
        else $error("bucket count beyond pool");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_SWEEP) |-> (int'(gd_reg) <= MG))
        else $error("global depth beyond directory");

    a_sweep_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> !s_tready)
        else $error("input taken during sweep");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !m_load)
        else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: tb/sv/eht_checker.sv
// eht_checker: watches the item and result channels of the hash table,
// keeps its own copy of the table and compares every result beat
// depends on eht_pkg; instantiated by testbench
`default_nettype none

module eht_checker import eht_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tuser,
    input  wire logic [95:0]  s_tdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [2:0]   m_tuser,
    input  wire logic [63:0]  m_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic         pready,
    output int                fail_count,
    output int                pending,
    output int                full_count,
    output int                hit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD   = 8;
    localparam int NBKT   = 256;
    localparam int NSLOT  = 4;
    localparam int DIRSZ  = 1 << MAXD;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value;
    } result_t;

    result_t     result_q[$];
    logic [3:0]  cfg_depth;
    logic [2:0]  cfg_cap;
    int          gdepth;
    int          dir_map[DIRSZ];
    int          ldepth[NBKT];
    int          nbuckets;
    logic [31:0] tkey[NBKT*NSLOT];
    logic [63:0] tval[NBKT*NSLOT];
    bit          tvld[NBKT*NSLOT];

    // clear the table to the configured starting depth
    function automatic void table_clear();
        int d;
        d = (cfg_depth > MAXD) ? MAXD : cfg_depth;
        while (d > 0 && (1 << d) > NBKT) d--;
        gdepth = d;
        for (int i = 0; i < DIRSZ; i++) dir_map[i] = i & ((1 << d) - 1);
        for (int i = 0; i < NBKT; i++) ldepth[i] = d;
        nbuckets = 1 << d;
        for (int i = 0; i < NBKT*NSLOT; i++) tvld[i] = 0;
    endfunction

    function automatic int lookup(int b, logic [31:0] k);
        for (int s = 0; s < NSLOT; s++)
            if (tvld[b*NSLOT+s] && tkey[b*NSLOT+s] == k) return b*NSLOT + s;
        return -1;
    endfunction

    function automatic bit split(int idx);
        int b, ld, nb, lm, dst, from, to, old;
        b = dir_map[idx % DIRSZ];
        ld = ldepth[b];
        if (ld >= gdepth && gdepth >= MAXD) return 0;
        if (nbuckets >= NBKT) return 0;
        if (ld >= gdepth) begin
            old = 1 << gdepth;
            for (int i = 0; i < old; i++) dir_map[old+i] = dir_map[i];
            gdepth++;
            ld = gdepth - 1;
        end
        nb = nbuckets++;
        ldepth[b] = ld + 1;
        ldepth[nb] = ld + 1;
        for (int s = 0; s < NSLOT; s++) tvld[nb*NSLOT+s] = 0;
        lm = (1 << (ld + 1)) - 1;
        for (int i = 0; i < (1 << gdepth); i++)
            if (dir_map[i] == b && (i & lm) != (idx & lm)) dir_map[i] = nb;
        dst = 0;
        for (int s = 0; s < NSLOT; s++) begin
            from = b*NSLOT + s;
            if (tvld[from] && (int'(tkey[from]) & lm) != (idx & lm)) begin
                to = nb*NSLOT + dst;
                tkey[to] = tkey[from];
                tval[to] = tval[from];
                tvld[to] = 1;
                tvld[from] = 0;
                dst++;
            end
        end
        return 1;
    endfunction

    // insert or update, splitting until the key fits or the table is full
    function automatic logic [2:0] table_insert(logic [31:0] k, logic [63:0] v);
        int idx, b, p, used, cap;
        cap = (cfg_cap < 1) ? 1 : ((cfg_cap > NSLOT) ? NSLOT : cfg_cap);
        forever begin
            idx = int'(k & ((32'd1 << gdepth) - 1));
            b = dir_map[idx];
            p = lookup(b, k);
            if (p >= 0) begin
                tval[p] = v;
                return ST_UPDATED;
            end
            used = 0;
            for (int s = 0; s < NSLOT; s++) used += tvld[b*NSLOT+s];
            if (used < cap) begin
                for (int s = 0; s < NSLOT; s++)
                    if (!tvld[b*NSLOT+s]) begin
                        tkey[b*NSLOT+s] = k;
                        tval[b*NSLOT+s] = v;
                        tvld[b*NSLOT+s] = 1;
                        return ST_NEW;
                    end
            end
            if (!split(idx)) return ST_FULL;
        end
    endfunction

    function automatic result_t predict(logic c, logic [31:0] k, logic [63:0] v);
        result_t r;
        int p;
        r = '0;
        if (c == CMD_INSERT) begin
            r.status = table_insert(k, v);
        end else begin
            p = lookup(dir_map[int'(k & ((32'd1 << gdepth) - 1))], k);
            if (p >= 0) begin
                r.status = ST_HIT;
                r.value = tval[p];
            end else begin
                r.status = ST_MISS;
            end
        end
        return r;
    endfunction

    // track register writes, predict on input beats, compare result beats
    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            cfg_cap = 3'd4;
            cfg_depth = 4'd2;
            table_clear();
            result_q.delete();
            fail_count = 0;
            full_count = 0;
            hit_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_BUCKET_CAP) begin
                    cfg_cap = pwdata[2:0];
                end else begin
                    cfg_depth = pwdata[3:0];
                    table_clear();
                end
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: %h %h", m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_tuser !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== exp_r.value) begin
                        $error("found_value expected %h actual %h", exp_r.value,
                               m_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                exp_r = predict(s_tuser, s_tdata[31:0], s_tdata[95:32]);
                if (exp_r.status == ST_FULL) full_count++;
                if (exp_r.status == ST_HIT) hit_count++;
                result_q = {result_q, exp_r};
            end
        end
        pending = result_q.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: drives gets and inserts into the hash table and gives the verdict
// depends on eht_pkg, eht_checker and extendible_hash_table_top
`default_nettype none

module testbench import eht_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tuser = 0;
    logic [95:0]  s_tdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [2:0]   m_tuser;
    logic [63:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count, pending, full_count, hit_count;
    int           item_count = 0;
    bit           sink_on = 1;

    logic [31:0]  key_pool[16];

    always #4 aclk = ~aclk;

    extendible_hash_table_top dut (.*);

    eht_checker chk (.*);

    // result side: random stall before each beat
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            w = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) w = 0;
            repeat (w) @(posedge aclk);
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            m_tready <= 0;
        end
    end

    task automatic reg_write(input logic reg_idx, input logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {reg_idx, 2'b00}; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    // wait until every result is back, then let the table sweep finish
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic send_item(input logic c, input logic [31:0] k, input logic [63:0] v,
                             input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 19) : 0;
        if (gaps && $urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tuser <= c;
        s_tdata <= {v, k};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        item_count++;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return key_pool[$urandom_range(0, 15)];
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic c;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 9) < 6) ? CMD_INSERT : CMD_GET;
            send_item(c, pick_key(), rnd64(), 1);
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes of key and value, miss, hit, update
        send_item(CMD_GET, 32'd0, '0, 0);
        send_item(CMD_INSERT, 32'd0, 64'h8000_0000_0000_0000, 0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_item(CMD_GET, 32'd0, '1, 0);
        send_item(CMD_GET, 32'hFFFF_FFFF, '0, 0);
        send_item(CMD_INSERT, 32'd0, '1, 0);
        send_item(CMD_GET, 32'd0, '0, 0);
        // many keys in one bucket force splits and directory doubling
        for (int i = 1; i < 10; i++)
            send_item(CMD_INSERT, i << 2, rnd64(), 0);
        send_item(CMD_GET, 32'd36, '0, 0);
        drain();

        // capacity one, depth zero: full quickly through the depth limit
        reg_write(REG_BUCKET_CAP, 32'd1);
        reg_write(REG_INIT_DEPTH, 32'd0);
        drain();
        for (int i = 0; i < 4; i++) send_item(CMD_INSERT, i << 8, rnd64(), 0);
        random_phase(60);
        drain();

        // capacity zero with depth beyond the limit, then capacity above the slot count with depth at the limit
        reg_write(REG_BUCKET_CAP, 32'd0);
        reg_write(REG_INIT_DEPTH, 32'd15);
        drain();
        random_phase(60);
        drain();
        reg_write(REG_BUCKET_CAP, 32'd7);
        reg_write(REG_INIT_DEPTH, 32'd8);
        drain();
        random_phase(60);
        drain();

        // mid settings, then lower capacity over filled buckets
        reg_write(REG_INIT_DEPTH, 32'd3);
        reg_write(REG_BUCKET_CAP, 32'd4);
        drain();
        random_phase(120);
        drain();
        reg_write(REG_BUCKET_CAP, 32'd2);
        random_phase(100);
        drain();
        reg_write(REG_INIT_DEPTH, 32'd1);
        reg_write(REG_BUCKET_CAP, 32'd3);
        drain();
        random_phase(100);
        drain();

        $display("items sent: %0d, get hits %0d, table-full answers %0d",
                 item_count, hit_count, full_count);
        $display("depths from zero to past the limit, capacities from zero to past a bucket");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
